// ===== rtl/dhc_pkg.sv =====
// ----------------------------------------------------------------------------
// dhc_pkg: shared types and constants of the detector hit calibrator
// Word layouts, register indexes, operation codes and energy constants.
// ----------------------------------------------------------------------------
package dhc_pkg;

   localparam int ARM_COUNT = 2;
   localparam int DIV_STEPS = 29;
   localparam int ENTRY_W = 56;

   localparam logic OP_HIT = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   localparam logic [1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_AMP_SCALE = 2'd1;
   localparam logic [1:0] CSR_TIME_SCALE = 2'd2;
   localparam logic [1:0] CSR_TIME_BASE = 2'd3;

   localparam logic [19:0] PED_MAX = 20'hFFFFF;
   localparam logic [30:0] PE_MAX = 31'h7FFFFFFF;

   localparam logic [7:0] E_COL_INNER = 8'd105;
   localparam logic [7:0] E_COL_OUTER = 8'd145;
   localparam logic [12:0] E_BASE_INNER = 13'd3008;
   localparam logic [12:0] E_SLOPE_INNER = 13'd26;
   localparam logic [12:0] E_BASE_OUTER = 13'd5740;
   localparam logic [12:0] E_SLOPE_OUTER = 13'd13;

   typedef struct packed {
      logic [19:0] threshold;
      logic [23:0] amp_scale;
      logic [15:0] time_scale;
      logic signed [23:0] time_base;
   } csr_type;

   typedef struct packed {
      logic bad;
      logic has_ped;
      logic [1:0] arm;
      logic [7:0] col;
      logic [18:0] integral;
      logic [15:0] ptime;
      logic [ENTRY_W-1:0] entry;
   } fitem_type;

   typedef struct packed {
      fitem_type f;
      logic [DIV_STEPS-1:0] quot;
   } qitem_type;

endpackage

// ===== rtl/dhc_ram.sv =====
// ----------------------------------------------------------------------------
// dhc_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module dhc_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 290
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dhc_front.sv =====
// ----------------------------------------------------------------------------
// dhc_front: accept, classify and look up hits
// Checks arm and column, writes loads to the calibration memory, reads it for
// hits, divides the event pedestal in a pipeline and fills a two-word queue.
// ----------------------------------------------------------------------------
module dhc_front #(
   parameter int NUM_COLUMNS = 145
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic                 operation,
   input  logic [1:0]           arm,
   input  logic [7:0]           column,
   input  logic [18:0]          raw_integral,
   input  logic [15:0]          raw_time,
   input  logic                 has_event_pedestal,
   input  logic [18:0]          pedestal_sum,
   input  logic [9:0]           samples_in_integral,
   input  logic [9:0]           samples_in_pedestal,
   input  logic [19:0]          load_pedestal,
   input  logic [15:0]          load_gain,
   input  logic signed [19:0]   load_time_offset,
   output logic                 q_valid,
   output dhc_pkg::qitem_type   q_item,
   input  logic                 q_pop
);

   localparam int DEPTH = NUM_COLUMNS * dhc_pkg::ARM_COUNT;
   localparam int AW = $clog2(DEPTH);
   localparam int S = dhc_pkg::DIV_STEPS;

   logic accept, fadv, is_valid, hit_acc, load_acc;
   logic [8:0] addr_full;
   logic [7:0] col_m1;
   logic [dhc_pkg::ENTRY_W-1:0] rdata;

   logic f1_valid_ff;
   dhc_pkg::fitem_type f1_ff;
   dhc_pkg::fitem_type f1_look;
   logic [18:0] f1_sum_ff;
   logic [9:0] f1_nint_ff, f1_nped_ff;

   logic f2_valid_ff;
   dhc_pkg::fitem_type f2_ff;
   logic [S-1:0] f2_num_ff;
   logic [9:0] f2_den_ff;

   logic dv_valid_ff [S];
   dhc_pkg::fitem_type dv_item_ff [S];
   logic [9:0] dv_rem_ff [S];
   logic [S-1:0] dv_quot_ff [S];
   logic [S-1:0] dv_num_ff [S];
   logic [9:0] dv_den_ff [S];
   logic [9:0] dv_rem_in [S];
   logic [S-1:0] dv_quot_in [S];

   dhc_pkg::qitem_type q_mem_ff [2];
   logic q_wptr_ff, q_rptr_ff;
   logic [1:0] q_count_ff;
   logic q_push, q_do_pop;

   assign is_valid = !arm[1] && (column != 8'd0) && (column <= 8'(NUM_COLUMNS));
   assign col_m1 = column - 8'd1;
   assign addr_full = {col_m1, arm[0]};

   assign fadv = !dv_valid_ff[S-1] || (q_count_ff != 2'd2);
   assign full = !fadv;
   assign accept = push && fadv;
   assign hit_acc = accept && (operation == dhc_pkg::OP_HIT);
   assign load_acc = accept && (operation == dhc_pkg::OP_LOAD) && is_valid;

   dhc_ram #(.WIDTH(dhc_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
      .clock(clock),
      .we(load_acc),
      .waddr(addr_full[AW-1:0]),
      .wdata({load_time_offset, load_gain, load_pedestal}),
      .re(hit_acc && is_valid),
      .raddr(addr_full[AW-1:0]),
      .rdata(rdata)
   );

   // The looked-up entry joins the word here; bad channels carry zeros.
   always_comb begin
      f1_look = f1_ff;
      f1_look.entry = f1_ff.bad ? '0 : rdata;
   end

   // One restoring step per divider stage.
   always_comb begin
      logic [10:0] shifted;
      logic [9:0] rem_src;
      logic [S-1:0] quot_src, num_src;
      logic [9:0] den_src;
      for (int k = 0; k < S; k++) begin
         if (k == 0) begin
            rem_src = '0;
            quot_src = '0;
            num_src = f2_num_ff;
            den_src = f2_den_ff;
         end else begin
            rem_src = dv_rem_ff[k-1];
            quot_src = dv_quot_ff[k-1];
            num_src = dv_num_ff[k-1];
            den_src = dv_den_ff[k-1];
         end
         shifted = {rem_src, num_src[S-1-k]};
         if (shifted >= {1'b0, den_src}) begin
            dv_rem_in[k] = 10'(shifted - {1'b0, den_src});
            dv_quot_in[k] = {quot_src[S-2:0], 1'b1};
         end else begin
            dv_rem_in[k] = shifted[9:0];
            dv_quot_in[k] = {quot_src[S-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         for (int k = 0; k < S; k++) begin
            dv_valid_ff[k] <= 1'b0;
         end
      end else if (fadv) begin
         f1_valid_ff <= hit_acc;
         f2_valid_ff <= f1_valid_ff;
         dv_valid_ff[0] <= f2_valid_ff;
         for (int k = 1; k < S; k++) begin
            dv_valid_ff[k] <= dv_valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fadv) begin
         f1_ff.bad <= !is_valid;
         f1_ff.has_ped <= has_event_pedestal;
         f1_ff.arm <= arm;
         f1_ff.col <= column;
         f1_ff.integral <= raw_integral;
         f1_ff.ptime <= raw_time;
         f1_ff.entry <= '0;
         f1_sum_ff <= pedestal_sum;
         f1_nint_ff <= samples_in_integral;
         f1_nped_ff <= samples_in_pedestal;

         f2_ff <= f1_look;
         f2_num_ff <= f1_sum_ff * f1_nint_ff;
         f2_den_ff <= f1_nped_ff;

         dv_item_ff[0] <= f2_ff;
         for (int k = 1; k < S; k++) begin
            dv_item_ff[k] <= dv_item_ff[k-1];
         end
         for (int k = 0; k < S; k++) begin
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_quot_ff[k] <= dv_quot_in[k];
         end
         dv_num_ff[0] <= f2_num_ff;
         dv_den_ff[0] <= f2_den_ff;
         for (int k = 1; k < S; k++) begin
            dv_num_ff[k] <= dv_num_ff[k-1];
            dv_den_ff[k] <= dv_den_ff[k-1];
         end
      end
   end

   // Two-word queue toward the back end.
   assign q_push = fadv && dv_valid_ff[S-1];
   assign q_valid = (q_count_ff != 2'd0);
   assign q_do_pop = q_pop && q_valid;
   assign q_item = q_mem_ff[q_rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wptr_ff <= 1'b0;
         q_rptr_ff <= 1'b0;
         q_count_ff <= 2'd0;
      end else begin
         if (q_push) begin
            q_wptr_ff <= !q_wptr_ff;
         end
         if (q_do_pop) begin
            q_rptr_ff <= !q_rptr_ff;
         end
         q_count_ff <= q_count_ff + {1'b0, q_push} - {1'b0, q_do_pop};
      end
   end

   // The last divider stage holds the full quotient of its own word.
   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem_ff[q_wptr_ff].f <= dv_item_ff[S-1];
         q_mem_ff[q_wptr_ff].quot <= dv_quot_ff[S-1];
      end
   end

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff != 2'd3) else $error("queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_count_ff == 2'd2 && !q_pop |-> !q_push) else $error("push into full queue");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      full |=> $stable(dv_item_ff[S-1])) else $error("divider moved while stalled");
`endif

endmodule

// ===== rtl/dhc_back.sv =====
// ----------------------------------------------------------------------------
// dhc_back: arithmetic back end of the hit calibrator
// Pedestal subtraction, threshold, amplitude and time scaling, rough energy.
// ----------------------------------------------------------------------------
module dhc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  dhc_pkg::csr_type     csr,
   input  logic                 q_valid,
   input  dhc_pkg::qitem_type   q_item,
   output logic                 q_pop,
   output logic                 empty,
   input  logic                 pop,
   output logic                 status,
   output logic [1:0]           hit_arm,
   output logic [7:0]           hit_column,
   output logic [19:0]          net_integral,
   output logic [30:0]          photoelectrons,
   output logic signed [31:0]   hit_time,
   output logic [12:0]          energy_mev
);

   logic badv, keep;
   logic [19:0] ped;
   logic signed [21:0] net;

   logic b1_valid_ff, b2_valid_ff, b3_valid_ff, o_valid_ff;
   logic b1_bad_ff, b2_bad_ff, b3_bad_ff;
   logic [1:0] b1_arm_ff, b2_arm_ff, b3_arm_ff;
   logic [7:0] b1_col_ff, b2_col_ff, b3_col_ff;
   logic [19:0] b1_net_ff, b2_net_ff, b3_net_ff;
   logic [15:0] b1_gain_ff, b2_gain_ff, b1_ptime_ff;
   logic signed [19:0] b1_off_ff;
   logic [43:0] b2_p1_ff;
   logic signed [20:0] b2_dt_ff;
   logic [37:0] b3_lo_ff, b3_hi_ff;
   logic signed [37:0] b3_t_ff;
   logic [59:0] pe_sum;
   logic [31:0] pe_full;
   logic [12:0] energy;

   logic o_status_ff;
   logic [1:0] o_arm_ff;
   logic [7:0] o_col_ff;
   logic [19:0] o_net_ff;
   logic [30:0] o_pe_ff;
   logic signed [31:0] o_time_ff;
   logic [12:0] o_energy_ff;

   assign badv = !o_valid_ff || pop;
   assign q_pop = badv && q_valid;

   always_comb begin
      if (q_item.f.has_ped) begin
         ped = (q_item.quot > {9'd0, dhc_pkg::PED_MAX}) ? dhc_pkg::PED_MAX
               : q_item.quot[19:0];
      end else begin
         ped = q_item.f.entry[19:0];
      end
      net = $signed({3'b000, q_item.f.integral}) - $signed({2'b00, ped});
      keep = q_item.f.bad || (net >= $signed({2'b00, csr.threshold}));
   end

   always_comb begin
      if (b3_col_ff >= 8'd1 && b3_col_ff <= dhc_pkg::E_COL_INNER) begin
         energy = dhc_pkg::E_BASE_INNER + 13'(b3_col_ff) * dhc_pkg::E_SLOPE_INNER;
      end else if (b3_col_ff > dhc_pkg::E_COL_INNER && b3_col_ff <= dhc_pkg::E_COL_OUTER) begin
         energy = dhc_pkg::E_BASE_OUTER
                  + 13'(b3_col_ff - dhc_pkg::E_COL_INNER) * dhc_pkg::E_SLOPE_OUTER;
      end else begin
         energy = '0;
      end
   end

   assign pe_sum = {b3_hi_ff, 22'd0} + {22'd0, b3_lo_ff};
   assign pe_full = pe_sum[59:28];

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (badv) begin
         b1_valid_ff <= q_valid && keep;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
         o_valid_ff <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (badv) begin
         b1_bad_ff <= q_item.f.bad;
         b1_arm_ff <= q_item.f.arm;
         b1_col_ff <= q_item.f.col;
         b1_net_ff <= net[19:0];
         b1_gain_ff <= q_item.f.entry[35:20];
         b1_off_ff <= $signed(q_item.f.entry[55:36]);
         b1_ptime_ff <= q_item.f.ptime;

         b2_bad_ff <= b1_bad_ff;
         b2_arm_ff <= b1_arm_ff;
         b2_col_ff <= b1_col_ff;
         b2_net_ff <= b1_net_ff;
         b2_gain_ff <= b1_gain_ff;
         b2_p1_ff <= b1_net_ff * csr.amp_scale;
         b2_dt_ff <= $signed({5'd0, b1_ptime_ff}) - $signed({b1_off_ff[19], b1_off_ff});

         b3_bad_ff <= b2_bad_ff;
         b3_arm_ff <= b2_arm_ff;
         b3_col_ff <= b2_col_ff;
         b3_net_ff <= b2_net_ff;
         b3_lo_ff <= b2_p1_ff[21:0] * b2_gain_ff;
         b3_hi_ff <= b2_p1_ff[43:22] * b2_gain_ff;
         b3_t_ff <= b2_dt_ff * $signed({1'b0, csr.time_scale});

         o_status_ff <= b3_bad_ff;
         o_arm_ff <= b3_arm_ff;
         o_col_ff <= b3_col_ff;
         if (b3_bad_ff) begin
            o_net_ff <= '0;
            o_pe_ff <= '0;
            o_time_ff <= '0;
            o_energy_ff <= '0;
         end else begin
            o_net_ff <= b3_net_ff;
            o_pe_ff <= pe_full[31] ? dhc_pkg::PE_MAX : pe_full[30:0];
            o_time_ff <= $signed({{2{b3_t_ff[37]}}, b3_t_ff[37:8]})
                         + $signed({{8{csr.time_base[23]}}, csr.time_base});
            o_energy_ff <= energy;
         end
      end
   end

   assign empty = !o_valid_ff;
   assign status = o_status_ff;
   assign hit_arm = o_arm_ff;
   assign hit_column = o_col_ff;
   assign net_integral = o_net_ff;
   assign photoelectrons = o_pe_ff;
   assign hit_time = o_time_ff;
   assign energy_mev = o_energy_ff;

`ifndef SYNTHESIS
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(o_pe_ff) && $stable(o_time_ff))
      else $error("result changed while waiting");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      !empty && status |-> net_integral == 20'd0 && energy_mev == 13'd0)
      else $error("status result carries data");
   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> badv && q_valid) else $error("queue popped while stalled");
`endif

endmodule

// ===== rtl/detector_hit_calibrator.sv =====
// ----------------------------------------------------------------------------
// detector_hit_calibrator: per-channel calibration of digitized hits
// Top level: configuration registers, front end and back end.
// ----------------------------------------------------------------------------
// Usage. Words enter on the req_ side like a queue: a word is taken at a
// rising edge with req_push high and req_full low. A load word writes the
// pedestal, gain and time offset of one channel; it gives no result. A hit
// word gives at most one result word on the rsp_ side: a calibrated hit, or
// a status word for a bad arm or column. Hits under the threshold vanish.
// The oldest result is shown while rsp_empty is low and taken with rsp_pop.
// Throughput is one word per cycle while req_full is low. After the accepting
// edge the word passes two lookup registers, a 29-stage pedestal divider
// that yields one quotient bit per stage, a queue slot and four arithmetic
// stages before rsp_empty drops.
// When the receiver stalls, the back end holds and the two-word queue fills;
// then the front end holds too and req_full rises. After the synchronous
// reset all pipelines and the queue are empty and the registers hold their
// defaults; the calibration memory is undefined until each channel is loaded.
// Registers are written through csr_ at any cycle with csr_write_enable high;
// the user must write only while the block is idle; nothing enforces this.
// ----------------------------------------------------------------------------
module detector_hit_calibrator #(
   parameter int NUM_COLUMNS = 145
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic                 req_operation,
   input  logic [1:0]           req_arm,
   input  logic [7:0]           req_column,
   input  logic [18:0]          req_raw_integral,
   input  logic [15:0]          req_raw_time,
   input  logic                 req_has_event_pedestal,
   input  logic [18:0]          req_pedestal_sum,
   input  logic [9:0]           req_samples_in_integral,
   input  logic [9:0]           req_samples_in_pedestal,
   input  logic [19:0]          req_load_pedestal,
   input  logic [15:0]          req_load_gain,
   input  logic signed [19:0]   req_load_time_offset,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic                 rsp_status,
   output logic [1:0]           rsp_hit_arm,
   output logic [7:0]           rsp_hit_column,
   output logic [19:0]          rsp_net_integral,
   output logic [30:0]          rsp_photoelectrons,
   output logic signed [31:0]   rsp_hit_time,
   output logic [12:0]          rsp_energy_mev,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [23:0]          csr_write_data
);

   dhc_pkg::csr_type csr_ff;
   logic q_valid, q_pop;
   dhc_pkg::qitem_type q_item;

   // Configuration registers; each write takes the low bits of the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.threshold <= 20'd500;
         csr_ff.amp_scale <= 24'd1678;
         csr_ff.time_scale <= 16'd4096;
         csr_ff.time_base <= 24'sd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            dhc_pkg::CSR_THRESHOLD: csr_ff.threshold <= csr_write_data[19:0];
            dhc_pkg::CSR_AMP_SCALE: csr_ff.amp_scale <= csr_write_data;
            dhc_pkg::CSR_TIME_SCALE: csr_ff.time_scale <= csr_write_data[15:0];
            dhc_pkg::CSR_TIME_BASE: csr_ff.time_base <= $signed(csr_write_data);
            default: ;
         endcase
      end
   end

   // The front end classifies, looks up and divides; the back end computes.
   dhc_front #(.NUM_COLUMNS(NUM_COLUMNS)) u_front (
      .clock(clock),
      .reset(reset),
      .push(req_push),
      .full(req_full),
      .operation(req_operation),
      .arm(req_arm),
      .column(req_column),
      .raw_integral(req_raw_integral),
      .raw_time(req_raw_time),
      .has_event_pedestal(req_has_event_pedestal),
      .pedestal_sum(req_pedestal_sum),
      .samples_in_integral(req_samples_in_integral),
      .samples_in_pedestal(req_samples_in_pedestal),
      .load_pedestal(req_load_pedestal),
      .load_gain(req_load_gain),
      .load_time_offset(req_load_time_offset),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop)
   );

   dhc_back u_back (
      .clock(clock),
      .reset(reset),
      .csr(csr_ff),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop),
      .empty(rsp_empty),
      .pop(rsp_pop),
      .status(rsp_status),
      .hit_arm(rsp_hit_arm),
      .hit_column(rsp_hit_column),
      .net_integral(rsp_net_integral),
      .photoelectrons(rsp_photoelectrons),
      .hit_time(rsp_hit_time),
      .energy_mev(rsp_energy_mev)
   );

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty) else $error("result present after reset");
   a_kept_over_threshold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_status |-> rsp_net_integral >= csr_ff.threshold)
      else $error("hit under threshold delivered");
   a_bad_arm_or_column: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_status |-> !rsp_hit_arm[1] && rsp_hit_column != 8'd0)
      else $error("bad channel delivered as calibrated hit");
`endif

endmodule

// ===== tb/hit_checker.sv =====
// ----------------------------------------------------------------------------
// hit_checker: calibration predictor and result scoreboard
// Watches the request, response and register ports of the hit calibrator,
// predicts each response word and compares it field by field in order.
// ----------------------------------------------------------------------------
module hit_checker #(
   parameter int NUM_COLUMNS = 145
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  logic                 req_operation,
   input  logic [1:0]           req_arm,
   input  logic [7:0]           req_column,
   input  logic [18:0]          req_raw_integral,
   input  logic [15:0]          req_raw_time,
   input  logic                 req_has_event_pedestal,
   input  logic [18:0]          req_pedestal_sum,
   input  logic [9:0]           req_samples_in_integral,
   input  logic [9:0]           req_samples_in_pedestal,
   input  logic [19:0]          req_load_pedestal,
   input  logic [15:0]          req_load_gain,
   input  logic signed [19:0]   req_load_time_offset,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  logic                 rsp_status,
   input  logic [1:0]           rsp_hit_arm,
   input  logic [7:0]           rsp_hit_column,
   input  logic [19:0]          rsp_net_integral,
   input  logic [30:0]          rsp_photoelectrons,
   input  logic signed [31:0]   rsp_hit_time,
   input  logic [12:0]          rsp_energy_mev,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [23:0]          csr_write_data,
   output int                   fail_count,
   output int                   pending_count,
   output int                   checked_count
);

   typedef struct {
      logic [19:0]        pedestal;
      logic [15:0]        gain;
      logic signed [19:0] offset;
   } channel_cal_type;

   typedef struct {
      logic               status;
      logic [1:0]         arm;
      logic [7:0]         column;
      logic [19:0]        net;
      logic [30:0]        pe;
      logic signed [31:0] hit_time;
      logic [12:0]        energy;
   } hit_result_type;

   channel_cal_type calib_mem [NUM_COLUMNS*dhc_pkg::ARM_COUNT];
   dhc_pkg::csr_type shadow_csr;
   hit_result_type expected_hits [$];

   function automatic logic [12:0] rough_energy(input logic [7:0] col);
      if (col >= 1 && col <= dhc_pkg::E_COL_INNER)
         return dhc_pkg::E_BASE_INNER + dhc_pkg::E_SLOPE_INNER * col;
      if (col > dhc_pkg::E_COL_INNER && col <= dhc_pkg::E_COL_OUTER)
         return dhc_pkg::E_BASE_OUTER
                + dhc_pkg::E_SLOPE_OUTER * (col - dhc_pkg::E_COL_INNER);
      return '0;
   endfunction

   // Works out the response for one accepted hit word; returns 0 if dropped.
   function automatic bit calibrate_hit(output hit_result_type r);
      longint ped, net, pe, t;
      int addr;
      bit good;
      good = req_arm < dhc_pkg::ARM_COUNT && req_column >= 1
             && req_column <= NUM_COLUMNS;
      r = '{default: '0};
      r.arm = req_arm;
      r.column = req_column;
      if (!good) begin
         r.status = 1'b1;
         return 1;
      end
      addr = (req_column - 1) * dhc_pkg::ARM_COUNT + req_arm;
      if (req_has_event_pedestal) begin
         if (req_samples_in_pedestal == 0) ped = dhc_pkg::PED_MAX;
         else begin
            ped = (longint'(req_pedestal_sum) * longint'(req_samples_in_integral))
                  / longint'(req_samples_in_pedestal);
            if (ped > dhc_pkg::PED_MAX) ped = dhc_pkg::PED_MAX;
         end
      end else
         ped = calib_mem[addr].pedestal;
      net = longint'(req_raw_integral) - ped;
      if (net < longint'(shadow_csr.threshold)) return 0;
      pe = (net * longint'(shadow_csr.amp_scale) * longint'(calib_mem[addr].gain)) >>> 28;
      if (pe > dhc_pkg::PE_MAX) pe = dhc_pkg::PE_MAX;
      t = (longint'(req_raw_time) - longint'(calib_mem[addr].offset))
          * longint'(shadow_csr.time_scale);
      t = (t >>> 8) + longint'(shadow_csr.time_base);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      r.net = net[19:0];
      r.pe = pe[30:0];
      r.hit_time = t[31:0];
      r.energy = rough_energy(req_column);
      return 1;
   endfunction

   always @(posedge clock) begin
      hit_result_type want;
      int addr;
      if (reset) begin
         shadow_csr <= '{threshold: 20'd500, amp_scale: 24'd1678,
                         time_scale: 16'd4096, time_base: 24'sd0};
         fail_count <= 0;
         checked_count <= 0;
         pending_count <= 0;
         expected_hits.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               dhc_pkg::CSR_THRESHOLD:  shadow_csr.threshold <= csr_write_data[19:0];
               dhc_pkg::CSR_AMP_SCALE:  shadow_csr.amp_scale <= csr_write_data;
               dhc_pkg::CSR_TIME_SCALE: shadow_csr.time_scale <= csr_write_data[15:0];
               dhc_pkg::CSR_TIME_BASE:  shadow_csr.time_base <= csr_write_data;
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            if (req_operation == dhc_pkg::OP_LOAD) begin
               if (req_arm < dhc_pkg::ARM_COUNT && req_column >= 1
                   && req_column <= NUM_COLUMNS) begin
                  addr = (req_column - 1) * dhc_pkg::ARM_COUNT + req_arm;
                  calib_mem[addr].pedestal = req_load_pedestal;
                  calib_mem[addr].gain = req_load_gain;
                  calib_mem[addr].offset = req_load_time_offset;
               end
            end else if (calibrate_hit(want))
               expected_hits.insert(expected_hits.size(), want);
         end
         if (rsp_pop && !rsp_empty) begin
            checked_count <= checked_count + 1;
            if (expected_hits.size() == 0) begin
               $error("unexpected response word arm %0d column %0d",
                      rsp_hit_arm, rsp_hit_column);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_hits.pop_front();
               if (rsp_status !== want.status || rsp_hit_arm !== want.arm
                   || rsp_hit_column !== want.column || rsp_net_integral !== want.net
                   || rsp_photoelectrons !== want.pe || rsp_hit_time !== want.hit_time
                   || rsp_energy_mev !== want.energy)
                  fail_count <= fail_count + 1;
               if (rsp_status !== want.status)
                  $error("status expected %0d got %0d", want.status, rsp_status);
               if (rsp_hit_arm !== want.arm)
                  $error("hit_arm expected %0d got %0d", want.arm, rsp_hit_arm);
               if (rsp_hit_column !== want.column)
                  $error("hit_column expected %0d got %0d", want.column, rsp_hit_column);
               if (rsp_net_integral !== want.net)
                  $error("net_integral expected %0d got %0d", want.net, rsp_net_integral);
               if (rsp_photoelectrons !== want.pe)
                  $error("photoelectrons expected %0d got %0d", want.pe, rsp_photoelectrons);
               if (rsp_hit_time !== want.hit_time)
                  $error("hit_time expected %0d got %0d", want.hit_time, rsp_hit_time);
               if (rsp_energy_mev !== want.energy)
                  $error("energy_mev expected %0d got %0d", want.energy, rsp_energy_mev);
            end
         end
         pending_count <= expected_hits.size();
      end
   end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the detector hit calibrator
// Loads every channel, runs directed corner words, then random words over
// several register settings and idling modes; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int COLS = 145;
   // A dropped hit may still be in flight.
   localparam int SETTLE_CYCLES = 48;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic               op;
      logic [1:0]         arm;
      logic [7:0]         column;
      logic [18:0]        integral;
      logic [15:0]        ptime;
      logic               has_ped;
      logic [18:0]        ped_sum;
      logic [9:0]         n_int;
      logic [9:0]         n_ped;
      logic [19:0]        ld_ped;
      logic [15:0]        ld_gain;
      logic signed [19:0] ld_offset;
   } req_word_type;

   logic clock, reset;
   logic req_push, req_full, req_operation, req_has_event_pedestal;
   logic [1:0] req_arm;
   logic [7:0] req_column;
   logic [18:0] req_raw_integral, req_pedestal_sum;
   logic [15:0] req_raw_time, req_load_gain;
   logic [9:0] req_samples_in_integral, req_samples_in_pedestal;
   logic [19:0] req_load_pedestal;
   logic signed [19:0] req_load_time_offset;
   logic rsp_empty, rsp_pop, rsp_status;
   logic [1:0] rsp_hit_arm;
   logic [7:0] rsp_hit_column;
   logic [19:0] rsp_net_integral;
   logic [30:0] rsp_photoelectrons;
   logic signed [31:0] rsp_hit_time;
   logic [12:0] rsp_energy_mev;
   logic csr_write_enable;
   logic [1:0] csr_index;
   logic [23:0] csr_write_data;

   int fail_count, pending_count, checked_count;
   int send_idle, recv_stall;       // percent of cycles idle on each side
   int hold_seq, hold_len;          // request for one long receiver hold-off
   int words_sent, settings_run;

   detector_hit_calibrator #(.NUM_COLUMNS(COLS)) dut (.*);

   hit_checker #(.NUM_COLUMNS(COLS)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The receiver pops at random; a hold-off request makes it refuse words
   // for a counted stretch so that the block backs up into req_full.
   initial begin
      int seen_seq, hold_left;
      seen_seq = 0;
      hold_left = 0;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != seen_seq) begin
            seen_seq = hold_seq;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else
            rsp_pop <= ($urandom_range(99) >= recv_stall);
      end
   end

   // The watchdog ends the run if no word moves on either side for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Offers one word and returns right after the edge that accepts it. The
   // full flag is sampled at the falling edge, away from any update.
   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_operation <= w.op;
      req_arm <= w.arm;
      req_column <= w.column;
      req_raw_integral <= w.integral;
      req_raw_time <= w.ptime;
      req_has_event_pedestal <= w.has_ped;
      req_pedestal_sum <= w.ped_sum;
      req_samples_in_integral <= w.n_int;
      req_samples_in_pedestal <= w.n_ped;
      req_load_pedestal <= w.ld_ped;
      req_load_gain <= w.ld_gain;
      req_load_time_offset <= w.ld_offset;
      forever begin
         @(negedge clock);
         if (!req_full) break;
      end
      @(posedge clock);
      words_sent++;
   endtask

   // Drops push, waits for every predicted word, then lets dropped hits clear.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [19:0] thr, input logic [23:0] amp,
                                 input logic [15:0] ts, input logic [23:0] tb);
      write_reg(dhc_pkg::CSR_THRESHOLD, {4'd0, thr});
      write_reg(dhc_pkg::CSR_AMP_SCALE, amp);
      write_reg(dhc_pkg::CSR_TIME_SCALE, {8'd0, ts});
      write_reg(dhc_pkg::CSR_TIME_BASE, tb);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      settings_run++;
   endtask

   function automatic req_word_type hit_word(input logic [1:0] arm, input logic [7:0] col,
                                             input logic [18:0] integral);
      req_word_type w;
      w = '{default: '0};
      w.op = dhc_pkg::OP_HIT;
      w.arm = arm;
      w.column = col;
      w.integral = integral;
      w.ptime = 16'($urandom);
      w.n_int = 10'd1;
      w.n_ped = 10'd1;
      return w;
   endfunction

   function automatic req_word_type load_word(input logic [1:0] arm, input logic [7:0] col,
                                              input logic [19:0] ped,
                                              input logic [15:0] gain,
                                              input logic [19:0] offset);
      req_word_type w;
      w = '{default: '0};
      w.op = dhc_pkg::OP_LOAD;
      w.arm = arm;
      w.column = col;
      w.ld_ped = ped;
      w.ld_gain = gain;
      w.ld_offset = offset;
      return w;
   endfunction

   // Random word: mostly well-formed hits on loaded channels with small
   // pedestals so that many pass the threshold, plus loads and bad channels.
   function automatic req_word_type random_word();
      req_word_type w;
      int pick;
      w.op = ($urandom_range(99) < 15) ? dhc_pkg::OP_LOAD : dhc_pkg::OP_HIT;
      pick = $urandom_range(99);
      w.arm = (pick < 6) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 3) w.column = 8'd0;
      else if (pick < 7) w.column = 8'($urandom_range(255, COLS + 1));
      else w.column = 8'($urandom_range(COLS, 1));
      w.integral = ($urandom_range(3) == 0) ? 19'($urandom_range(4095)) : 19'($urandom);
      w.ptime = 16'($urandom);
      w.has_ped = 1'($urandom_range(1));
      w.ped_sum = ($urandom_range(3) == 0) ? 19'($urandom) : 19'($urandom_range(8191));
      w.n_int = 10'($urandom_range(1023, 1));
      w.n_ped = ($urandom_range(49) == 0) ? 10'd0 : 10'($urandom_range(1023, 1));
      w.ld_ped = ($urandom_range(4) == 0) ? 20'($urandom) : 20'($urandom_range(2047));
      w.ld_gain = 16'($urandom);
      w.ld_offset = 20'($urandom);
      return w;
   endfunction

   initial begin
      req_word_type w;
      int count;
      reset = 1'b1;
      req_push = 1'b0;
      req_operation = dhc_pkg::OP_HIT;
      req_arm = '0;
      req_column = '0;
      req_raw_integral = '0;
      req_raw_time = '0;
      req_has_event_pedestal = 1'b0;
      req_pedestal_sum = '0;
      req_samples_in_integral = '0;
      req_samples_in_pedestal = '0;
      req_load_pedestal = '0;
      req_load_gain = '0;
      req_load_time_offset = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      send_idle = 0;
      recv_stall = 0;
      hold_seq = 0;
      hold_len = 0;
      words_sent = 0;
      settings_run = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every channel gets an entry first, since the memory starts undefined.
      for (int c = 1; c <= COLS; c++)
         for (int a = 0; a < dhc_pkg::ARM_COUNT; a++)
            send_word(load_word(2'(a), 8'(c), 20'($urandom_range(1023)),
                                16'($urandom), 20'($urandom)));

      // Directed corners under the reset defaults.
      send_word(load_word(2'd0, 8'd1, 20'd0, 16'hFFFF, 20'h80000));
      w = hit_word(2'd0, 8'd1, 19'h7FFFF);
      w.ptime = 16'hFFFF;
      send_word(w);
      w.ptime = 16'h0000;
      send_word(w);
      send_word(load_word(2'd1, 8'd145, 20'hFFFFF, 16'd0, 20'h7FFFF));
      send_word(hit_word(2'd1, 8'd145, 19'h7FFFF));   // negative net is dropped
      send_word(hit_word(2'd1, 8'd145, 19'd0));
      send_word(load_word(2'd3, 8'd10, 20'd5, 16'd5, 20'd5)); // ignored, bad arm
      send_word(load_word(2'd0, 8'd0, 20'd5, 16'd5, 20'd5));  // ignored, bad column
      send_word(load_word(2'd1, 8'd105, 20'd100, 16'h1000, 20'd0));
      send_word(load_word(2'd0, 8'd106, 20'd100, 16'h1000, 20'hFFFFF));
      send_word(hit_word(2'd1, 8'd105, 19'd600));      // last inner column, at threshold
      send_word(hit_word(2'd0, 8'd106, 19'd600));      // first outer column
      send_word(hit_word(2'd1, 8'd105, 19'd599));      // one under threshold
      send_word(hit_word(2'd1, 8'd105, 19'd598));      // two under threshold
      send_word(hit_word(2'd2, 8'd50, 19'd1000));      // bad arm status
      send_word(hit_word(2'd3, 8'd255, 19'd0));
      send_word(hit_word(2'd0, 8'd0, 19'd1000));       // bad column status
      send_word(hit_word(2'd1, 8'd146, 19'd1000));
      w = hit_word(2'd0, 8'd106, 19'h7FFFF);
      w.has_ped = 1'b1;
      w.ped_sum = 19'd0;
      w.n_ped = 10'd0;                                  // zero pedestal samples
      send_word(w);
      w.ped_sum = 19'h7FFFF;
      w.n_int = 10'h3FF;
      w.n_ped = 10'd1;                                  // event pedestal saturates
      send_word(w);
      w.ped_sum = 19'd1000;
      w.n_int = 10'd7;
      w.n_ped = 10'd3;
      send_word(w);
      drain();

      // Random phases; each sets all four registers and one idling mode.
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: write_settings(20'd500, 24'd1678, 16'd4096, 24'd0);
            1: write_settings(20'd0, 24'hFFFFFF, 16'hFFFF, 24'h7FFFFF);
            2: write_settings(20'd0, 24'd0, 16'd0, 24'h800000);
            4: write_settings(20'hFFFFF, 24'($urandom), 16'($urandom), 24'($urandom));
            6: write_settings(20'd0, 24'hFFFFFF, 16'hFFFF, 24'h800000);
            default: write_settings(20'($urandom_range(3000)), 24'($urandom),
                                    16'($urandom), 24'($urandom));
         endcase
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 71; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 71; end
            default: begin send_idle = 12; recv_stall = 12; end
         endcase
         count = 24;
         if (p == 2) begin
            // A long hold-off while words keep coming backs the block up.
            hold_len = 400;
            hold_seq++;
            count = 60;
         end else if (p == 4)
            count = 10;
         for (int i = 0; i < count; i++) begin
            if (i == 12 && p != 2)
               drain();          // pause until every result has come back
            send_word(random_word());
         end
         drain();
      end

      $display("Covered %0d words across %0d register settings and four idling modes.",
               words_sent, settings_run);
      $display("%0d response words compared, %0d mismatching.", checked_count, fail_count);
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
